FILE: rtl/json_token_lexer_unit_assert.svh
// assertion macros for the json token lexer checker
// no dependencies; included by the checker file
`ifndef JSON_TOKEN_LEXER_UNIT_ASSERT_SVH
`define JSON_TOKEN_LEXER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define JTL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("json token lexer check failed");

// next-cycle implication, clocked on clk, off during reset
`define JTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("json token lexer check failed");

`endif

FILE: rtl/jtl_pkg.sv
// shared types and constants for the json token lexer
// no dependencies; used by every module of the block
package jtl_pkg;

    localparam int POS_BITS_DEF = 32;
    localparam int QDEPTH       = 4;

    localparam logic [3:0] T_STRING = 4'd0;
    localparam logic [3:0] T_KEY    = 4'd1;
    localparam logic [3:0] T_NUMBER = 4'd2;
    localparam logic [3:0] T_TRUE   = 4'd3;
    localparam logic [3:0] T_FALSE  = 4'd4;
    localparam logic [3:0] T_NULL   = 4'd5;
    localparam logic [3:0] T_LBRK   = 4'd6;
    localparam logic [3:0] T_RBRK   = 4'd7;
    localparam logic [3:0] T_LBRC   = 4'd8;
    localparam logic [3:0] T_RBRC   = 4'd9;
    localparam logic [3:0] T_COMMA  = 4'd10;
    localparam logic [3:0] T_END    = 4'd11;

    localparam logic [1:0] E_ZERO    = 2'd0;
    localparam logic [1:0] E_STRAY   = 2'd1;
    localparam logic [1:0] E_KEYWORD = 2'd2;

    typedef struct packed {
        logic [3:0]  tok_type;
        logic [31:0] start;
        logic [31:0] length;
        logic [1:0]  end_kind;
        logic        last;
    } token_t;

    typedef struct packed {
        logic   v0;
        logic   v1;
        token_t tok0;
        token_t tok1;
    } lex_result_t;

    // keyword characters by kind (true, false, null) and index
    function automatic logic [7:0] kw_char(input logic [1:0] kk, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (kk)
            2'd0:
            begin
                case (idx)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (idx)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            default:
            begin
                case (idx)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/json_token_lexer_unit.sv
// json token lexer top level: input register, lexer core, result queue
// depends on jtl_pkg, jtl_lex, jtl_outq
//
//  channel  valid      ready      payload
//  input    in_valid   in_ready   in_byte
//  output   out_valid  out_ready  token_type token_start token_length end_kind last_of_run
//
// one byte a cycle while the queue has room: a byte is registered, then decoded,
// and its zero to two tokens go into a four-entry queue once that queue has room
// a byte's first token shows on out_valid after the input register and the queue register
// two-token bytes are limited by the output, one token a cycle while out_ready is high
// in_ready drops while a byte waits for two free queue entries
// reset clears the lexer state, the position count and the queue
module json_token_lexer_unit #(
    parameter int POS_BITS = jtl_pkg::POS_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_type,
    output logic [31:0] token_start,
    output logic [31:0] token_length,
    output logic [1:0]  end_kind,
    output logic        last_of_run
);
    import jtl_pkg::*;

    logic        byte_valid_reg;
    logic [7:0]  byte_reg;
    logic        room, step;
    lex_result_t res;
    token_t      head_tok;

    assign step     = byte_valid_reg && room;
    assign in_ready = !byte_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (in_ready)
            byte_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            byte_reg <= in_byte;
    end

    jtl_lex #(
        .POS_BITS (POS_BITS)
    ) u_lex (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_byte (byte_reg),
        .res     (res)
    );

    jtl_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (step),
        .wr_res   (res),
        .room     (room),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rd_tok   (head_tok)
    );

    assign token_type   = head_tok.tok_type;
    assign token_start  = head_tok.start;
    assign token_length = head_tok.length;
    assign end_kind     = head_tok.end_kind;
    assign last_of_run  = head_tok.last;

endmodule

FILE: rtl/jtl_lex.sv
// lexer state and per-byte token decode for the json token lexer
// depends on jtl_pkg
module jtl_lex #(
    parameter int POS_BITS = jtl_pkg::POS_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          in_byte,
    output jtl_pkg::lex_result_t res
);
    import jtl_pkg::*;

    typedef enum logic [7:0] {
        M_IDLE  = 8'b0000_0001,
        M_STR   = 8'b0000_0010,
        M_AFTER = 8'b0000_0100,
        M_KW    = 8'b0000_1000,
        M_INT   = 8'b0001_0000,
        M_FRAC  = 8'b0010_0000,
        M_EXP0  = 8'b0100_0000,
        M_EXPD  = 8'b1000_0000
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [1:0]          kind_reg, kind_next;
    logic [2:0]          idx_reg, idx_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] begin_reg, begin_next;
    logic [POS_BITS-1:0] send_reg, send_next;

    function automatic logic [31:0] to32(input logic [POS_BITS-1:0] v);
        logic [POS_BITS+31:0] w;
        w = {32'b0, v};
        return w[31:0];
    endfunction

    function automatic token_t mk(input logic [3:0] ty, input logic [31:0] st,
                                  input logic [31:0] ln, input logic [1:0] ek);
        token_t t;
        t.tok_type = ty;
        t.start    = st;
        t.length   = ln;
        t.end_kind = ek;
        t.last     = 1'b0;
        return t;
    endfunction

    logic [7:0]          c;
    logic [POS_BITS-1:0] numlen, strlen;
    logic                is_dig, is_e;

    // between-token handling of the current byte
    mode_t               i_mode;
    logic                i_emit, i_restart, i_kw, i_begin;
    logic [POS_BITS-1:0] i_begin_val;
    logic [1:0]          i_kind;
    token_t              i_tok;

    assign c      = in_byte;
    assign numlen = pos_reg - begin_reg;
    assign strlen = send_reg - begin_reg;
    assign is_dig = (c >= "0") && (c <= "9");
    assign is_e   = (c == "e") || (c == "E");

    always_comb
    begin
        i_mode      = M_IDLE;
        i_emit      = 1'b0;
        i_restart   = 1'b0;
        i_kw        = 1'b0;
        i_begin     = 1'b0;
        i_begin_val = pos_reg;
        i_kind      = 2'd0;
        i_tok       = mk(T_END, to32(pos_reg), 32'd0, E_ZERO);
        if (c == " " || c == "\t" || c == "\n" || c == "\r")
        begin
            i_mode = M_IDLE;
        end
        else if (c == "\"")
        begin
            i_mode      = M_STR;
            i_begin     = 1'b1;
            i_begin_val = pos_reg + 1'b1;
        end
        else if (c == "t" || c == "f" || c == "n")
        begin
            i_mode  = M_KW;
            i_kw    = 1'b1;
            i_begin = 1'b1;
            i_kind  = (c == "t") ? 2'd0 : ((c == "f") ? 2'd1 : 2'd2);
        end
        else if (c == "-" || is_dig)
        begin
            i_mode  = M_INT;
            i_begin = 1'b1;
        end
        else if (c == "[" || c == "]" || c == "{" || c == "}" || c == ",")
        begin
            i_emit = 1'b1;
            case (c)
                "[":     i_tok = mk(T_LBRK, to32(pos_reg), 32'd1, E_ZERO);
                "]":     i_tok = mk(T_RBRK, to32(pos_reg), 32'd1, E_ZERO);
                "{":     i_tok = mk(T_LBRC, to32(pos_reg), 32'd1, E_ZERO);
                "}":     i_tok = mk(T_RBRC, to32(pos_reg), 32'd1, E_ZERO);
                default: i_tok = mk(T_COMMA, to32(pos_reg), 32'd1, E_ZERO);
            endcase
        end
        else
        begin
            i_emit    = 1'b1;
            i_restart = 1'b1;
            i_tok     = mk(T_END, to32(pos_reg), 32'd0, (c == 8'h00) ? E_ZERO : E_STRAY);
        end
    end

    logic [1:0] kk;
    logic [2:0] kw_len, idx, idx_inc;
    logic       do_idle, restart;

    assign kk      = (kind_reg == 2'd3) ? 2'd0 : kind_reg;
    assign kw_len  = (kk == 2'd1) ? 3'd5 : 3'd4;
    assign idx     = (idx_reg < kw_len) ? idx_reg : 3'd0;
    assign idx_inc = idx + 3'd1;

    always_comb
    begin
        mode_next  = mode_reg;
        kind_next  = kind_reg;
        idx_next   = idx_reg;
        begin_next = begin_reg;
        send_next  = send_reg;
        pos_next   = pos_reg + 1'b1;
        res.v0     = 1'b0;
        res.v1     = 1'b0;
        res.tok0   = i_tok;
        res.tok1   = i_tok;
        do_idle    = 1'b0;
        restart    = 1'b0;
        case (mode_reg)
            M_STR:
            begin
                if (c == "\"")
                begin
                    send_next = pos_reg;
                    mode_next = M_AFTER;
                end
                else if (c == 8'h00)
                begin
                    res.v0   = 1'b1;
                    res.tok0 = mk(T_STRING, to32(begin_reg), to32(numlen), E_ZERO);
                    do_idle  = 1'b1;
                end
            end
            M_AFTER:
            begin
                res.v0 = 1'b1;
                if (c == ":")
                begin
                    res.tok0  = mk(T_KEY, to32(begin_reg), to32(strlen), E_ZERO);
                    mode_next = M_IDLE;
                end
                else
                begin
                    res.tok0 = mk(T_STRING, to32(begin_reg), to32(strlen), E_ZERO);
                    do_idle  = 1'b1;
                end
            end
            M_KW:
            begin
                if (c == kw_char(kk, idx) && idx != 3'd0)
                begin
                    idx_next = idx_inc;
                    if (idx_inc == kw_len)
                    begin
                        res.v0    = 1'b1;
                        res.tok0  = mk(T_TRUE + {2'b00, kk}, to32(begin_reg),
                                       {29'b0, kw_len}, E_ZERO);
                        mode_next = M_IDLE;
                    end
                end
                else
                begin
                    restart  = 1'b1;
                    res.v0   = 1'b1;
                    res.tok0 = mk(T_END, to32(pos_reg), 32'd0, E_KEYWORD);
                end
            end
            M_INT:
            begin
                if (c == ".")
                    mode_next = M_FRAC;
                else if (is_e)
                    mode_next = M_EXP0;
                else if (!is_dig)
                begin
                    res.v0   = 1'b1;
                    res.tok0 = mk(T_NUMBER, to32(begin_reg), to32(numlen), E_ZERO);
                    do_idle  = 1'b1;
                end
            end
            M_FRAC:
            begin
                if (is_e)
                    mode_next = M_EXP0;
                else if (!is_dig)
                begin
                    res.v0   = 1'b1;
                    res.tok0 = mk(T_NUMBER, to32(begin_reg), to32(numlen), E_ZERO);
                    do_idle  = 1'b1;
                end
            end
            M_EXP0:
            begin
                if (is_dig || c == "+" || c == "-")
                    mode_next = M_EXPD;
                else
                begin
                    res.v0   = 1'b1;
                    res.tok0 = mk(T_NUMBER, to32(begin_reg), to32(numlen), E_ZERO);
                    do_idle  = 1'b1;
                end
            end
            M_EXPD:
            begin
                if (!is_dig)
                begin
                    res.v0   = 1'b1;
                    res.tok0 = mk(T_NUMBER, to32(begin_reg), to32(numlen), E_ZERO);
                    do_idle  = 1'b1;
                end
            end
            default:
            begin
                do_idle = 1'b1;
            end
        endcase

        if (do_idle)
        begin
            mode_next = i_mode;
            restart   = i_restart;
            if (i_begin)
                begin_next = i_begin_val;
            if (i_kw)
            begin
                kind_next = i_kind;
                idx_next  = 3'd1;
            end
            if (i_emit)
            begin
                if (res.v0)
                    res.v1 = 1'b1;
                else
                    res.v0 = 1'b1;
            end
        end

        // last flag goes on the final item of this byte
        res.tok0.last = res.v0 && !res.v1;
        res.tok1.last = res.v1;

        if (restart)
        begin
            mode_next  = M_IDLE;
            kind_next  = 2'd0;
            idx_next   = 3'd0;
            pos_next   = '0;
            begin_next = '0;
            send_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            kind_reg  <= 2'd0;
            idx_reg   <= 3'd0;
            pos_reg   <= '0;
            begin_reg <= '0;
            send_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            kind_reg  <= kind_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            send_reg  <= send_next;
        end
    end

endmodule

FILE: rtl/jtl_outq.sv
// small result queue taking up to two tokens a cycle, handing out one while rd_ready is high
// depends on jtl_pkg
module jtl_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  jtl_pkg::lex_result_t wr_res,
    output logic                 room,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output jtl_pkg::token_t      rd_tok
);
    import jtl_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    token_t             entry_reg [QDEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PTR_W-1:0]   tail_inc;
    logic               push0, push1, pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign push0    = wr_en && wr_res.v0;
    assign push1    = wr_en && wr_res.v1;
    assign rd_valid = (cnt_reg != '0);
    assign rd_tok   = entry_reg[head_reg];
    assign pop      = rd_valid && rd_ready;
    assign room     = (cnt_reg <= CNT_W'(QDEPTH - 2));
    assign tail_inc = ptr_inc(tail_reg);

    always_comb
    begin
        head_next = pop ? ptr_inc(head_reg) : head_reg;
        tail_next = tail_reg;
        if (push1)
            tail_next = ptr_inc(tail_inc);
        else if (push0)
            tail_next = tail_inc;
        cnt_next = cnt_reg + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
            entry_reg[tail_reg] <= wr_res.tok0;
        if (push1)
            entry_reg[tail_inc] <= wr_res.tok1;
    end

endmodule

FILE: rtl/jtl_checker.sv
// port-level checks for the json token lexer, bound to the top level
// depends on jtl_pkg and json_token_lexer_unit_assert.svh
`include "json_token_lexer_unit_assert.svh"

module jtl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  in_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  token_type,
    input logic [31:0] token_start,
    input logic [31:0] token_length,
    input logic [1:0]  end_kind,
    input logic        last_of_run
);
    import jtl_pkg::*;

    logic is_symbol;
    assign is_symbol = (token_type == T_LBRK) || (token_type == T_RBRK) ||
                       (token_type == T_LBRC) || (token_type == T_RBRC) ||
                       (token_type == T_COMMA);

    `JTL_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid)
    `JTL_ASSERT_NOW(a_kind_only_end, out_valid && token_type != T_END, end_kind == E_ZERO)
    `JTL_ASSERT_NOW(a_end_empty, out_valid && token_type == T_END, token_length == 32'd0 && last_of_run)
    `JTL_ASSERT_NOW(a_symbol_len, out_valid && is_symbol, token_length == 32'd1 && last_of_run)

endmodule

bind json_token_lexer_unit jtl_checker u_chk (.*);
